// ----- hdl/lms_pkg.sv -----
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants for the display line and mode sequencer.
// ----------------------------------------------------------------------------
package lms_pkg;

  // Line timing.
  localparam int unsigned DOTS_PER_LINE = 456;
  localparam int unsigned VISIBLE_LINES = 144;
  localparam int unsigned LAST_LINE     = 153;
  localparam int unsigned OAM_END_DOT   = 80;
  localparam int unsigned XFER_END_DOT  = 248;

  localparam int unsigned DotW = $clog2(DOTS_PER_LINE);
  localparam int unsigned SumW = DotW + 1;

  // Commands carried by an input beat.
  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_CONTROL = 2'd1,
    CMD_STATUS  = 2'd2,
    CMD_COMPARE = 2'd3
  } cmd_e;

  // Display modes as they appear in status bits 1:0.
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Bit positions inside status_upper (status bits 7..2).
  localparam int unsigned SU_COINC    = 0;
  localparam int unsigned SU_HBL_IE   = 1;
  localparam int unsigned SU_VBL_IE   = 2;
  localparam int unsigned SU_OAM_IE   = 3;
  localparam int unsigned SU_COINC_IE = 4;
  localparam int unsigned SU_STICKY   = 5;

  localparam int unsigned CTRL_ENABLE = 7;

  // Reset values.
  localparam logic [DotW-1:0] DOT_RESET  = DotW'(248);
  localparam logic [1:0]      MODE_RESET = MODE_VBLANK;
  localparam logic [5:0]      SU_RESET   = 6'h21;
  localparam logic [7:0]      CTRL_RESET = 8'h91;

  typedef struct packed {
    logic [DotW-1:0] dot;
    logic [7:0]      line;
    logic [1:0]      mode;
    logic [5:0]      su;
    logic [7:0]      ctrl;
    logic [7:0]      cmp;
  } lms_state_t;

  typedef struct packed {
    logic vblank;
    logic stat;
    logic hblank;
  } lms_pulse_t;

endpackage

// ----- hdl/lms_step.sv -----
// ----------------------------------------------------------------------------
// lms_step
// Next-state and pulse logic for one command beat.
// ----------------------------------------------------------------------------
module lms_step (
  input  logic [1:0]          command_i,
  input  logic [7:0]          data_i,
  input  logic [7:0]          cycle_count_i,
  input  lms_pkg::lms_state_t cur_i,
  output lms_pkg::lms_state_t nxt_o,
  output lms_pkg::lms_pulse_t pulse_o
);
  import lms_pkg::*;

  logic [SumW-1:0] dot_sum;
  logic            wrap;
  logic [DotW-1:0] dot_new;
  logic [1:0]      mode_v;
  logic [1:0]      target;
  logic [7:0]      line_v;
  logic            line_changed;
  logic            mode_changed;

  // Dot counter modulo the line length: one conditional subtract.
  assign dot_sum = {1'b0, cur_i.dot} + {{(SumW - 8){1'b0}}, cycle_count_i};
  assign wrap    = dot_sum >= SumW'(DOTS_PER_LINE);
  assign dot_new = wrap ? DotW'(dot_sum - SumW'(DOTS_PER_LINE)) : dot_sum[DotW-1:0];

  always_comb begin
    if (dot_new < DotW'(OAM_END_DOT)) begin
      target = MODE_OAM;
    end else if (dot_new < DotW'(XFER_END_DOT)) begin
      target = MODE_XFER;
    end else begin
      target = MODE_HBLANK;
    end
  end

  always_comb begin
    nxt_o        = cur_i;
    pulse_o      = '0;
    mode_v       = cur_i.mode;
    line_v       = cur_i.line;
    line_changed = 1'b0;
    mode_changed = 1'b0;
    unique case (cmd_e'(command_i))
      CMD_CONTROL: begin
        nxt_o.ctrl = data_i;
        if (!data_i[CTRL_ENABLE]) begin
          nxt_o.mode = MODE_HBLANK;
          nxt_o.line = '0;
          nxt_o.dot  = '0;
        end
      end
      CMD_STATUS: begin
        nxt_o.su = {cur_i.su[SU_STICKY] | data_i[7], data_i[6:2]};
      end
      CMD_COMPARE: begin
        nxt_o.cmp = data_i;
        if (cur_i.line == data_i) begin
          nxt_o.su[SU_COINC] = 1'b1;
          pulse_o.stat       = cur_i.su[SU_COINC_IE];
        end
      end
      CMD_ADVANCE: begin
        if (cur_i.ctrl[CTRL_ENABLE]) begin
          nxt_o.dot = dot_new;
          // Line wrap; a wrap on line 0 in mode 1 only leaves mode 1.
          if (wrap) begin
            if (cur_i.line != 8'd0 || cur_i.mode != MODE_VBLANK) begin
              line_v       = cur_i.line + 8'd1;
              line_changed = 1'b1;
            end else begin
              mode_v = MODE_OAM;
            end
          end
          if (line_v < 8'(VISIBLE_LINES) && mode_v != MODE_VBLANK) begin
            if (mode_v != target) begin
              mode_v       = target;
              mode_changed = 1'b1;
            end
          end
          if (mode_changed && line_v < 8'(VISIBLE_LINES)) begin
            if (mode_v == MODE_HBLANK) begin
              pulse_o.hblank = 1'b1;
              if (cur_i.su[SU_HBL_IE]) pulse_o.stat = 1'b1;
            end
            if (mode_v == MODE_OAM && cur_i.su[SU_OAM_IE]) pulse_o.stat = 1'b1;
          end
          if (line_changed && line_v == 8'(VISIBLE_LINES)) begin
            mode_v         = MODE_VBLANK;
            pulse_o.vblank = 1'b1;
            if (cur_i.su[SU_VBL_IE]) pulse_o.stat = 1'b1;
          end else if (line_v == 8'(LAST_LINE)) begin
            if (line_v == cur_i.cmp && cur_i.su[SU_COINC_IE]) pulse_o.stat = 1'b1;
            line_v = '0;
          end
          // Coincidence on a line change; line 0 counts only in mode 1.
          if (line_changed && line_v == cur_i.cmp) begin
            if (line_v != 8'd0 || mode_v == MODE_VBLANK) begin
              nxt_o.su[SU_COINC] = 1'b1;
              if (cur_i.su[SU_COINC_IE]) pulse_o.stat = 1'b1;
            end
          end else begin
            nxt_o.su[SU_COINC] = 1'b0;
          end
          nxt_o.line = line_v;
          nxt_o.mode = mode_v;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ----- hdl/lcd_line_mode_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// lcd_line_mode_sequencer_top
// Display line and mode sequencer with valid/ready input and result channels.
// ----------------------------------------------------------------------------
// A result beat passes through the input register and then the result register;
// it waits in the input register while the result register is full. Throughput:
// one beat per cycle while the result channel is not stalled; the dot, line and
// mode registers are updated in the same cycle the result register is loaded.
// Reset: asynchronous, active low; dots 248, line 0, mode 1, status 0x85,
// control 0x91, compare 0; both pipeline registers come up empty.
// ----------------------------------------------------------------------------
module lcd_line_mode_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_i,
  input  logic [7:0] cycle_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] line_o,
  output logic [7:0] status_byte_o,
  output logic [7:0] control_byte_o,
  output logic       vblank_request_o,
  output logic       stat_request_o,
  output logic       hblank_start_o
);
  import lms_pkg::*;

  // Input register stage. It is free when empty or when its beat moves on.
  logic       in_v_q;
  logic [1:0] cmd_q;
  logic [7:0] data_q;
  logic [7:0] cyc_q;

  // Architectural state of the sequencer.
  lms_state_t st_q;
  lms_state_t st_d;
  lms_pulse_t pulse;

  // Result register stage.
  logic       out_v_q;
  logic [7:0] line_q;
  logic [7:0] status_q;
  logic [7:0] ctrl_q;
  lms_pulse_t pulse_q;

  logic res_ready;
  logic fire;

  // The result register can load when it is empty or is being drained, so a
  // waiting result blocks the input side only while out_ready_i is low.
  assign res_ready  = !out_v_q || out_ready_i;
  assign fire       = in_v_q && res_ready;
  assign in_ready_o = !in_v_q || res_ready;

  lms_step u_step (
    .command_i     (cmd_q),
    .data_i        (data_q),
    .cycle_count_i (cyc_q),
    .cur_i         (st_q),
    .nxt_o         (st_d),
    .pulse_o       (pulse)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q  <= command_i;
      data_q <= data_i;
      cyc_q  <= cycle_count_i;
    end
  end

  // State is committed exactly when a beat leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.dot  <= DOT_RESET;
      st_q.line <= '0;
      st_q.mode <= MODE_RESET;
      st_q.su   <= SU_RESET;
      st_q.ctrl <= CTRL_RESET;
      st_q.cmp  <= '0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      line_q   <= st_d.line;
      status_q <= {st_d.su, st_d.mode};
      ctrl_q   <= st_d.ctrl;
      pulse_q  <= pulse;
    end
  end

  assign out_valid_o      = out_v_q;
  assign line_o           = line_q;
  assign status_byte_o    = status_q;
  assign control_byte_o   = ctrl_q;
  assign vblank_request_o = pulse_q.vblank;
  assign stat_request_o   = pulse_q.stat;
  assign hblank_start_o   = pulse_q.hblank;

endmodule
